@@ rtl/tct_pkg.sv @@
package tct_pkg;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2,
    KIND_IDLE  = 2'd3
  } tct_kind_e;

  typedef enum logic [1:0] {
    ACC_LATCH = 2'd0,
    ACC_LSB   = 2'd1,
    ACC_MSB   = 2'd2,
    ACC_WORD  = 2'd3
  } tct_access_e;

  localparam logic [1:0] ADDR_CTRL = 2'd3;

  localparam logic [2:0] MODE_INT_TC    = 3'd0;
  localparam logic [2:0] MODE_ONE_SHOT  = 3'd1;
  localparam logic [2:0] MODE_RATE_GEN  = 3'd2;
  localparam logic [2:0] MODE_SQUARE    = 3'd3;
  localparam logic [2:0] MODE_SW_STROBE = 3'd4;
  localparam logic [2:0] MODE_HW_STROBE = 3'd5;

  localparam logic [16:0] FULL_RANGE = 17'h10000;

  // One accepted request as seen by every channel.
  typedef struct packed {
    logic       accept;
    tct_kind_e  kind;
    logic [1:0] addr;
    logic [7:0] data;
  } tct_req_t;

endpackage

@@ rtl/three_channel_interval_timer.sv @@
// Three-channel interval timer in the style of the classic 8253. Each request is a timer
// tick carrying the three gate levels, a bus write (address 3 is the control word,
// addresses 0 to 2 the counters), a bus read or an idle request, and it produces exactly one
// result: the read byte with its valid flag and the output levels of all channels after the
// request. The channel registers update at the accepting edge and the result lands in the
// output register, so a new request is taken every cycle as long as the result side keeps
// up. The output register is the only buffer, so ready drops only while a result waits and
// the consumer is not ready. Channels beyond NUM_CHANNELS are absent: their output levels
// read low and reads of their addresses return no data.
module three_channel_interval_timer #(
  parameter int unsigned NUM_CHANNELS = 3
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] mode_i,
  input  logic [1:0] addr_i,
  input  logic [7:0] write_data_i,
  input  logic       gate_zero_i,
  input  logic       gate_one_i,
  input  logic       gate_two_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_data_o,
  output logic       read_valid_o,
  output logic       out_zero_o,
  output logic       out_one_o,
  output logic       out_two_o
);
  import tct_pkg::*;

  localparam logic [2:0] NumCh = 3'(NUM_CHANNELS);

  tct_req_t   req;
  logic [2:0] gate;
  logic [7:0] rd_byte [4];
  logic [2:0] lvl_d;
  logic       rd_valid_d;
  logic [7:0] rd_data_d;

  logic       out_valid_q;
  logic [7:0] read_data_q;
  logic       read_valid_q;
  logic [2:0] lvl_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign req.accept = in_valid_i && in_ready_o;
  assign req.kind   = tct_kind_e'(mode_i);
  assign req.addr   = addr_i;
  assign req.data   = write_data_i;
  assign gate       = {gate_two_i, gate_one_i, gate_zero_i};
  assign rd_byte[3] = 8'd0;

  for (genvar c = 0; c < 3; c++) begin : g_ch
    if (c < NUM_CHANNELS) begin : g_on
      tct_channel #(.CH(c)) u_ch (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .req_i     (req),
        .gate_i    (gate[c]),
        .rd_byte_o (rd_byte[c]),
        .level_d_o (lvl_d[c])
      );
    end else begin : g_off
      assign rd_byte[c] = 8'd0;
      assign lvl_d[c]   = 1'b0;
    end
  end

  assign rd_valid_d = (req.kind == KIND_READ) && ({1'b0, addr_i} < NumCh);
  assign rd_data_d  = rd_valid_d ? rd_byte[addr_i] : 8'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.accept) begin
      read_data_q  <= rd_data_d;
      read_valid_q <= rd_valid_d;
      lvl_q        <= lvl_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_data_o  = read_data_q;
  assign read_valid_o = read_valid_q;
  assign out_zero_o   = lvl_q[0];
  assign out_one_o    = lvl_q[1];
  assign out_two_o    = lvl_q[2];

endmodule

@@ rtl/tct_channel.sv @@
module tct_channel #(
  parameter int unsigned CH = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tct_pkg::tct_req_t req_i,
  input  logic              gate_i,
  output logic [7:0]        rd_byte_o,
  output logic              level_d_o
);
  import tct_pkg::*;

  localparam logic [1:0] ChId = CH[1:0];

  logic [16:0] cnt_q, cnt_d;
  logic [16:0] reload_q, reload_d;
  logic [15:0] latch_q, latch_d;
  logic        held_q, held_d;
  logic [2:0]  mode_q, mode_d;
  logic        bcd_q, bcd_d;
  tct_access_e acc_q, acc_d;
  logic        prog_q, prog_d;
  logic        counting_q, counting_d;
  logic        loaded_q, loaded_d;
  logic        xfer_q, xfer_d;
  logic        lbp_q, lbp_d;
  logic [7:0]  lbs_q, lbs_d;
  logic        hbn_q, hbn_d;
  logic        lvl_q, lvl_d;

  logic        sel_cnt, sel_cw;
  logic [16:0] cur;
  logic [15:0] dec;
  logic [15:0] rd_src;
  logic        load_en;
  logic [15:0] load_raw;
  logic [2:0]  cw_mode;

  // Binary or four-digit BCD decrement; digits above nine get no correction.
  function automatic logic [15:0] count_down(input logic [15:0] v, input logic bcd);
    logic [15:0] res;
    logic        borrow;
    logic [3:0]  nib;
    res    = '0;
    borrow = 1'b1;
    if (!bcd) begin
      res = v - 16'd1;
    end else begin
      for (int i = 0; i < 4; i++) begin
        nib = v[i*4 +: 4];
        if (borrow && (nib == 4'd0)) begin
          res[i*4 +: 4] = 4'd9;
          borrow        = 1'b1;
        end else begin
          res[i*4 +: 4] = nib - {3'd0, borrow};
          borrow        = 1'b0;
        end
      end
    end
    return res;
  endfunction

  assign sel_cnt = (req_i.addr == ChId);
  assign sel_cw  = (req_i.addr == ADDR_CTRL) && (req_i.data[7:6] == ChId);
  assign cur     = xfer_q ? reload_q : cnt_q;
  assign dec     = count_down(cur[15:0], bcd_q);
  assign rd_src  = held_q ? latch_q : cnt_q[15:0];
  assign cw_mode = (req_i.data[3] & req_i.data[2]) ? {1'b0, req_i.data[2:1]} : req_i.data[3:1];

  always_comb begin
    unique case (acc_q)
      ACC_LSB:  rd_byte_o = rd_src[7:0];
      ACC_MSB:  rd_byte_o = rd_src[15:8];
      ACC_WORD: rd_byte_o = hbn_q ? rd_src[15:8] : rd_src[7:0];
      default:  rd_byte_o = 8'd0;
    endcase
  end

  always_comb begin
    cnt_d      = cnt_q;
    reload_d   = reload_q;
    latch_d    = latch_q;
    held_d     = held_q;
    mode_d     = mode_q;
    bcd_d      = bcd_q;
    acc_d      = acc_q;
    prog_d     = prog_q;
    counting_d = counting_q;
    loaded_d   = loaded_q;
    xfer_d     = xfer_q;
    lbp_d      = lbp_q;
    lbs_d      = lbs_q;
    hbn_d      = hbn_q;
    lvl_d      = lvl_q;
    load_en    = 1'b0;
    load_raw   = '0;

    if (req_i.accept) begin
      unique case (req_i.kind)
        KIND_TICK: begin
          if (prog_q && loaded_q) begin
            cnt_d  = cur;
            xfer_d = 1'b0;
            if (counting_q) begin
              case (mode_q)
                MODE_INT_TC: begin
                  if (gate_i) begin
                    cnt_d = {1'b0, dec};
                    if (dec == 16'd0) lvl_d = 1'b1;
                  end
                end
                MODE_ONE_SHOT: begin
                  cnt_d = {1'b0, dec};
                  if (dec == 16'd0) begin
                    lvl_d      = 1'b1;
                    counting_d = 1'b0;
                  end
                end
                MODE_RATE_GEN: begin
                  if (!gate_i) begin
                    lvl_d = 1'b1;
                  end else begin
                    cnt_d = {1'b0, dec};
                    if (dec == 16'd1) begin
                      lvl_d = 1'b0;
                    end else if (dec == 16'd0) begin
                      lvl_d = 1'b1;
                      cnt_d = reload_q;
                    end
                  end
                end
                MODE_SQUARE: begin
                  // Binary step of two whatever the BCD flag says.
                  if (!gate_i) begin
                    lvl_d = 1'b1;
                  end else if (cur <= 17'd2) begin
                    lvl_d = ~lvl_q;
                    cnt_d = reload_q;
                  end else begin
                    cnt_d = cur - 17'd2;
                  end
                end
                MODE_SW_STROBE, MODE_HW_STROBE: begin
                  if ((mode_q == MODE_HW_STROBE) || gate_i) begin
                    cnt_d = {1'b0, dec};
                    if (dec == 16'd0) begin
                      lvl_d = 1'b0;
                    end else if (!lvl_q) begin
                      lvl_d      = 1'b1;
                      counting_d = 1'b0;
                    end
                  end
                end
                default: ;
              endcase
            end
          end
        end
        KIND_WRITE: begin
          if (sel_cw) begin
            if (tct_access_e'(req_i.data[5:4]) == ACC_LATCH) begin
              if (!held_q) begin
                latch_d = cnt_q[15:0];
                held_d  = 1'b1;
                hbn_d   = 1'b0;
              end
            end else begin
              mode_d     = cw_mode;
              bcd_d      = req_i.data[0];
              acc_d      = tct_access_e'(req_i.data[5:4]);
              prog_d     = 1'b1;
              counting_d = 1'b0;
              loaded_d   = 1'b0;
              xfer_d     = 1'b1;
              lbp_d      = 1'b0;
              hbn_d      = 1'b0;
              held_d     = 1'b0;
              lvl_d      = (cw_mode != MODE_INT_TC);
            end
          end else if (sel_cnt && prog_q) begin
            unique case (acc_q)
              ACC_LSB: begin
                load_en  = 1'b1;
                load_raw = {8'd0, req_i.data};
              end
              ACC_MSB: begin
                load_en  = 1'b1;
                load_raw = {req_i.data, 8'd0};
              end
              ACC_WORD: begin
                if (!lbp_q) begin
                  lbs_d = req_i.data;
                  lbp_d = 1'b1;
                end else begin
                  lbp_d    = 1'b0;
                  load_en  = 1'b1;
                  load_raw = {req_i.data, lbs_q};
                end
              end
              default: ;
            endcase
          end
        end
        KIND_READ: begin
          if (sel_cnt) begin
            unique case (acc_q)
              ACC_LSB, ACC_MSB: held_d = 1'b0;
              ACC_WORD: begin
                hbn_d = ~hbn_q;
                if (hbn_q) held_d = 1'b0;
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end

    // A loaded value of zero stands for the full count range.
    if (load_en) begin
      reload_d   = (load_raw == 16'd0) ? FULL_RANGE : {1'b0, load_raw};
      loaded_d   = 1'b1;
      xfer_d     = 1'b1;
      counting_d = 1'b1;
    end
  end

  assign level_d_o = lvl_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      reload_q   <= '0;
      latch_q    <= '0;
      held_q     <= 1'b0;
      mode_q     <= MODE_INT_TC;
      bcd_q      <= 1'b0;
      acc_q      <= ACC_LATCH;
      prog_q     <= 1'b0;
      counting_q <= 1'b0;
      loaded_q   <= 1'b0;
      xfer_q     <= 1'b0;
      lbp_q      <= 1'b0;
      lbs_q      <= '0;
      hbn_q      <= 1'b0;
      lvl_q      <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      reload_q   <= reload_d;
      latch_q    <= latch_d;
      held_q     <= held_d;
      mode_q     <= mode_d;
      bcd_q      <= bcd_d;
      acc_q      <= acc_d;
      prog_q     <= prog_d;
      counting_q <= counting_d;
      loaded_q   <= loaded_d;
      xfer_q     <= xfer_d;
      lbp_q      <= lbp_d;
      lbs_q      <= lbs_d;
      hbn_q      <= hbn_d;
      lvl_q      <= lvl_d;
    end
  end

endmodule

@@ rtl/tct_checker.sv @@
module tct_assertions (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [1:0] mode_i,
  input logic [1:0] addr_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] read_data_o,
  input logic       read_valid_o
);
  import tct_pkg::*;

  // Every accepted request yields a result in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted request produced no result");

  // The block takes a new request whenever its result register is free.
  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input stalled although the result side is free");

  // A result without read data carries a zero byte.
  a_no_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !read_valid_o |-> read_data_o == 8'd0)
    else $error("read byte set on a result without read data");

  // Only reads of a counter address can return data.
  a_read_only_counter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (addr_i == ADDR_CTRL || mode_i != KIND_READ)
    |=> !read_valid_o)
    else $error("read data returned for a request that is no counter read");

  // A stalled result holds its read byte.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(read_data_o) && out_valid_o)
    else $error("stalled result changed");

endmodule

bind three_channel_interval_timer tct_assertions u_tct_checker (.*);

@@ test/tct_checker.sv @@
`timescale 1ns / 100ps

module tct_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [1:0] mode_i,
  input  logic [1:0] addr_i,
  input  logic [7:0] write_data_i,
  input  logic       gate_zero_i,
  input  logic       gate_one_i,
  input  logic       gate_two_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] read_data_i,
  input  logic       read_valid_i,
  input  logic       out_zero_i,
  input  logic       out_one_i,
  input  logic       out_two_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         checked_o
);
  import tct_pkg::*;

  localparam int unsigned NUM_CH = 3;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic [2:0] levels;
  } timer_result_t;

  timer_result_t expected_q[$];

  // Per-channel copy of the timer state.
  logic [16:0] count_q[NUM_CH];
  logic [16:0] reload_q[NUM_CH];
  logic [15:0] latch_val[NUM_CH];
  logic        latch_valid[NUM_CH];
  logic [2:0]  ch_mode[NUM_CH];
  logic        ch_bcd[NUM_CH];
  tct_access_e ch_access[NUM_CH];
  logic        ch_armed[NUM_CH];
  logic        ch_running[NUM_CH];
  logic        ch_loaded[NUM_CH];
  logic        reload_due[NUM_CH];
  logic        lsb_waiting[NUM_CH];
  logic [7:0]  lsb_byte[NUM_CH];
  logic        msb_turn[NUM_CH];
  logic        ch_out[NUM_CH];

  function automatic void clear_timer_state();
    int c;
    for (c = 0; c < NUM_CH; c++) begin
      count_q[c] = '0;
      reload_q[c] = '0;
      latch_val[c] = '0;
      latch_valid[c] = 1'b0;
      ch_mode[c] = MODE_INT_TC;
      ch_bcd[c] = 1'b0;
      ch_access[c] = ACC_LATCH;
      ch_armed[c] = 1'b0;
      ch_running[c] = 1'b0;
      ch_loaded[c] = 1'b0;
      reload_due[c] = 1'b0;
      lsb_waiting[c] = 1'b0;
      lsb_byte[c] = '0;
      msb_turn[c] = 1'b0;
      ch_out[c] = 1'b0;
    end
  endfunction

  // In BCD each nibble borrows from the next; nibbles above 9 are not corrected.
  function automatic logic [16:0] count_down_value(logic [16:0] v, logic bcd_mode);
    logic [16:0] res;
    int          d;
    int          i;
    logic        borrow;
    if (!bcd_mode) return {1'b0, v[15:0] - 16'd1};
    if (v == '0) return 17'h09999;
    res = '0;
    borrow = 1'b1;
    for (i = 0; i < 4; i++) begin
      d = int'(v[i*4 +: 4]) - int'(borrow);
      if (d < 0) begin
        d += 10;
        borrow = 1'b1;
      end else begin
        borrow = 1'b0;
      end
      res[i*4 +: 4] = d[3:0];
    end
    return res;
  endfunction

  function automatic void load_count(int c, logic [16:0] raw);
    reload_q[c] = (raw == '0) ? FULL_RANGE : raw;
    ch_loaded[c] = 1'b1;
    reload_due[c] = 1'b1;
    ch_running[c] = 1'b1;
  endfunction

  function automatic void apply_control_word(logic [7:0] v);
    int          c;
    logic [2:0]  m;
    c = int'(v[7:6]);
    if (c >= NUM_CH) return;
    if (tct_access_e'(v[5:4]) == ACC_LATCH) begin
      // A second latch command is ignored until the held value is read out.
      if (!latch_valid[c]) begin
        latch_val[c] = count_q[c][15:0];
        latch_valid[c] = 1'b1;
        msb_turn[c] = 1'b0;
      end
      return;
    end
    m = v[3:1];
    if (m > MODE_HW_STROBE) m = {1'b0, m[1:0]};
    ch_mode[c] = m;
    ch_bcd[c] = v[0];
    ch_access[c] = tct_access_e'(v[5:4]);
    ch_armed[c] = 1'b1;
    ch_running[c] = 1'b0;
    ch_loaded[c] = 1'b0;
    reload_due[c] = 1'b1;
    lsb_waiting[c] = 1'b0;
    msb_turn[c] = 1'b0;
    latch_valid[c] = 1'b0;
    ch_out[c] = (m == MODE_INT_TC) ? 1'b0 : 1'b1;
  endfunction

  function automatic void store_count_byte(int c, logic [7:0] v);
    if (!ch_armed[c]) return;
    case (ch_access[c])
      ACC_LSB: load_count(c, {9'd0, v});
      ACC_MSB: load_count(c, {1'b0, v, 8'd0});
      ACC_WORD: begin
        if (!lsb_waiting[c]) begin
          lsb_byte[c] = v;
          lsb_waiting[c] = 1'b1;
        end else begin
          lsb_waiting[c] = 1'b0;
          load_count(c, {1'b0, v, lsb_byte[c]});
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] fetch_count_byte(int c);
    logic [15:0] v;
    logic [7:0]  r;
    v = latch_valid[c] ? latch_val[c] : count_q[c][15:0];
    r = '0;
    case (ch_access[c])
      ACC_LSB: begin
        r = v[7:0];
        latch_valid[c] = 1'b0;
      end
      ACC_MSB: begin
        r = v[15:8];
        latch_valid[c] = 1'b0;
      end
      ACC_WORD: begin
        if (!msb_turn[c]) begin
          r = v[7:0];
          msb_turn[c] = 1'b1;
        end else begin
          r = v[15:8];
          msb_turn[c] = 1'b0;
          latch_valid[c] = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void tick_channel(int c, logic gate);
    if (!ch_armed[c] || !ch_loaded[c]) return;
    if (reload_due[c]) begin
      count_q[c] = reload_q[c];
      reload_due[c] = 1'b0;
    end
    if (!ch_running[c]) return;
    case (ch_mode[c])
      MODE_INT_TC: begin
        if (!gate) return;
        count_q[c] = count_down_value(count_q[c], ch_bcd[c]);
        if (count_q[c] == '0) ch_out[c] = 1'b1;
      end
      MODE_ONE_SHOT: begin
        count_q[c] = count_down_value(count_q[c], ch_bcd[c]);
        if (count_q[c] == '0) begin
          ch_out[c] = 1'b1;
          ch_running[c] = 1'b0;
        end
      end
      MODE_RATE_GEN: begin
        if (!gate) begin
          ch_out[c] = 1'b1;
          return;
        end
        count_q[c] = count_down_value(count_q[c], ch_bcd[c]);
        if (count_q[c] == 17'd1) begin
          ch_out[c] = 1'b0;
        end else if (count_q[c] == '0) begin
          ch_out[c] = 1'b1;
          count_q[c] = reload_q[c];
        end
      end
      MODE_SQUARE: begin
        if (!gate) begin
          ch_out[c] = 1'b1;
          return;
        end
        // The square wave always steps by two in binary, BCD flag or not.
        if (count_q[c] <= 17'd2) begin
          ch_out[c] = ~ch_out[c];
          count_q[c] = reload_q[c];
        end else begin
          count_q[c] = count_q[c] - 17'd2;
        end
      end
      MODE_SW_STROBE, MODE_HW_STROBE: begin
        if (ch_mode[c] == MODE_SW_STROBE && !gate) return;
        count_q[c] = count_down_value(count_q[c], ch_bcd[c]);
        if (count_q[c] == '0) begin
          ch_out[c] = 1'b0;
        end else if (!ch_out[c]) begin
          ch_out[c] = 1'b1;
          ch_running[c] = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void apply_request(tct_kind_e kind, logic [1:0] addr, logic [7:0] data,
                                        logic [2:0] gates);
    timer_result_t res;
    int            c;
    res = '0;
    case (kind)
      KIND_TICK: begin
        for (c = 0; c < NUM_CH; c++) tick_channel(c, gates[c]);
      end
      KIND_WRITE: begin
        if (addr == ADDR_CTRL) apply_control_word(data);
        else if (int'(addr) < NUM_CH) store_count_byte(int'(addr), data);
      end
      KIND_READ: begin
        if (int'(addr) < NUM_CH) begin
          res.data = fetch_count_byte(int'(addr));
          res.valid = 1'b1;
        end
      end
      default: ;
    endcase
    for (c = 0; c < NUM_CH; c++) res.levels[c] = ch_out[c];
    expected_q.push_back(res);
  endfunction

  task automatic report_error(input string msg);
    $display("[%0t] mismatch at result %0d: %s", $time, checked_o, msg);
    fail_count_o++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_error($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    timer_result_t want;
    if (!rst_ni) begin
      clear_timer_state();
      expected_q.delete();
      fail_count_o = 0;
      checked_o = 0;
    end else begin
      // The result leaving at this edge always belongs to an earlier request.
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report_error("result arrived with no request outstanding");
        end else begin
          want = expected_q.pop_front();
          check_field("read_data", read_data_i, want.data);
          check_field("read_valid", {7'd0, read_valid_i}, {7'd0, want.valid});
          check_field("out_zero", {7'd0, out_zero_i}, {7'd0, want.levels[0]});
          check_field("out_one", {7'd0, out_one_i}, {7'd0, want.levels[1]});
          check_field("out_two", {7'd0, out_two_i}, {7'd0, want.levels[2]});
          checked_o++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        apply_request(tct_kind_e'(mode_i), addr_i, write_data_i,
                      {gate_two_i, gate_one_i, gate_zero_i});
      end
    end
    pending_o = expected_q.size();
  end

endmodule

@@ test/three_channel_interval_timer_tb.sv @@
`timescale 1ns / 100ps

module three_channel_interval_timer_tb;
  import tct_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 800;

  logic       clk;
  logic       rst_n;
  logic       req_valid;
  logic       req_ready;
  logic [1:0] req_kind;
  logic [1:0] req_addr;
  logic [7:0] req_data;
  logic       gate_zero;
  logic       gate_one;
  logic       gate_two;
  logic       rsp_valid;
  logic       rsp_ready;
  logic [7:0] read_data;
  logic       read_valid;
  logic       out_zero;
  logic       out_one;
  logic       out_two;

  int fail_count;
  int pending;
  int checked;

  int kind_count[4];
  int useful_sent;
  int burst_left;
  int seq_count;
  int cycle_count;
  int stall_style;
  int style_left;
  int stall_phase;

  three_channel_interval_timer #(
    .NUM_CHANNELS(3)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (req_valid),
    .in_ready_o  (req_ready),
    .mode_i      (req_kind),
    .addr_i      (req_addr),
    .write_data_i(req_data),
    .gate_zero_i (gate_zero),
    .gate_one_i  (gate_one),
    .gate_two_i  (gate_two),
    .out_valid_o (rsp_valid),
    .out_ready_i (rsp_ready),
    .read_data_o (read_data),
    .read_valid_o(read_valid),
    .out_zero_o  (out_zero),
    .out_one_o   (out_one),
    .out_two_o   (out_two)
  );

  tct_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (req_valid),
    .in_ready_i  (req_ready),
    .mode_i      (req_kind),
    .addr_i      (req_addr),
    .write_data_i(req_data),
    .gate_zero_i (gate_zero),
    .gate_one_i  (gate_one),
    .gate_two_i  (gate_two),
    .out_valid_i (rsp_valid),
    .out_ready_i (rsp_ready),
    .read_data_i (read_data),
    .read_valid_i(read_valid),
    .out_zero_i  (out_zero),
    .out_one_i   (out_one),
    .out_two_i   (out_two),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // The receiver switches between stretches of full speed, random stalls and a
  // slow periodic accept.
  always @(negedge clk) begin
    if (style_left == 0) begin
      stall_style = $urandom_range(0, 2);
      style_left = $urandom_range(10, 120);
    end
    style_left--;
    stall_phase++;
    case (stall_style)
      0: rsp_ready <= 1'b1;
      1: rsp_ready <= ($urandom_range(0, 2) != 0);
      default: rsp_ready <= (stall_phase % 4 == 0);
    endcase
  end

  function automatic logic [7:0] ctrl_word(logic [1:0] ch, tct_access_e acc, logic [2:0] m,
                                           logic bcd);
    return {ch, acc, m, bcd};
  endfunction

  // Enters just after an accepting edge (or after reset) and returns at the
  // edge that accepts this request.
  task automatic send_req(input tct_kind_e kind, input logic [1:0] addr, input logic [7:0] data,
                          input logic [2:0] gates);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    req_valid <= 1'b1;
    req_kind <= kind;
    req_addr <= addr;
    req_data <= data;
    {gate_two, gate_one, gate_zero} <= gates;
    do @(posedge clk); while (!req_ready);
    kind_count[int'(kind)]++;
    if (kind != KIND_IDLE) useful_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic directed_checks();
    send_req(KIND_READ, 2'd0, 8'h00, 3'b000);
    send_req(KIND_WRITE, 2'd0, 8'h55, 3'b111);
    send_req(KIND_IDLE, 2'd1, 8'hFF, 3'b111);
    send_req(KIND_READ, ADDR_CTRL, 8'h00, 3'b000);
    send_req(KIND_WRITE, ADDR_CTRL, ctrl_word(2'd3, ACC_WORD, MODE_SQUARE, 1'b0), 3'b000);
    // Channel 0 counts 3 in mode 0, holds on a low gate and runs past terminal count.
    send_req(KIND_WRITE, ADDR_CTRL, ctrl_word(2'd0, ACC_LSB, MODE_INT_TC, 1'b0), 3'b111);
    send_req(KIND_WRITE, 2'd0, 8'd3, 3'b111);
    send_req(KIND_TICK, 2'd0, 8'h00, 3'b110);
    repeat (4) send_req(KIND_TICK, 2'd0, 8'h00, 3'b111);
    // Mode code 7 folds to the square wave; a zero load is the full range.
    send_req(KIND_WRITE, ADDR_CTRL, ctrl_word(2'd1, ACC_WORD, 3'b111, 1'b1), 3'b111);
    send_req(KIND_WRITE, 2'd1, 8'h00, 3'b111);
    send_req(KIND_WRITE, 2'd1, 8'h00, 3'b111);
    send_req(KIND_TICK, 2'd0, 8'h00, 3'b111);
    send_req(KIND_READ, 2'd1, 8'h00, 3'b111);
    send_req(KIND_READ, 2'd1, 8'h00, 3'b111);
    // Mode code 6 folds to the rate generator; the BCD count wraps from zero.
    send_req(KIND_WRITE, ADDR_CTRL, ctrl_word(2'd2, ACC_MSB, 3'b110, 1'b1), 3'b111);
    send_req(KIND_WRITE, 2'd2, 8'h00, 3'b111);
    send_req(KIND_TICK, 2'd0, 8'h00, 3'b111);
    send_req(KIND_WRITE, ADDR_CTRL, ctrl_word(2'd0, ACC_LATCH, MODE_INT_TC, 1'b0), 3'b111);
    send_req(KIND_WRITE, ADDR_CTRL, ctrl_word(2'd0, ACC_LATCH, MODE_INT_TC, 1'b0), 3'b111);
    send_req(KIND_TICK, 2'd0, 8'h00, 3'b111);
    send_req(KIND_READ, 2'd0, 8'h00, 3'b111);
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(4, 16)) begin
      send_req(tct_kind_e'($urandom_range(0, 3)), 2'($urandom), 8'($urandom),
               3'($urandom));
    end
  endtask

  // Program one channel, load it (now and then only partly or not at all) and exercise it with
  // ticks, reads, latches and reloads.
  task automatic run_sequence();
    logic [1:0]  ch;
    logic [2:0]  m;
    logic        bcd;
    tct_access_e acc;
    logic [15:0] val;
    logic [2:0]  gates;
    int          pick;
    ch = 2'($urandom_range(0, 2));
    m = 3'($urandom_range(0, 7));
    bcd = ($urandom_range(0, 3) == 0);
    acc = tct_access_e'($urandom_range(1, 3));
    seq_count++;
    send_req(KIND_WRITE, ADDR_CTRL, ctrl_word(ch, acc, m, bcd), 3'($urandom));
    case ($urandom_range(0, 7))
      0: val = 16'h0000;
      1: val = 16'($urandom);
      default: val = 16'($urandom_range(1, 14));
    endcase
    if ($urandom_range(0, 7) != 0) begin
      case (acc)
        ACC_LSB: send_req(KIND_WRITE, ch, val[7:0], 3'($urandom));
        ACC_MSB: send_req(KIND_WRITE, ch, ($urandom_range(0, 3) == 0) ? val[15:8] :
                          8'($urandom_range(1, 2)), 3'($urandom));
        default: begin
          send_req(KIND_WRITE, ch, val[7:0], 3'($urandom));
          if ($urandom_range(0, 7) != 0) send_req(KIND_WRITE, ch, val[15:8], 3'($urandom));
        end
      endcase
    end
    repeat ($urandom_range(4, 32)) begin
      pick = $urandom_range(0, 19);
      gates = 3'($urandom);
      gates[ch] = ($urandom_range(0, 6) != 0);
      if (pick < 13) send_req(KIND_TICK, 2'($urandom), 8'($urandom), gates);
      else if (pick < 16) send_req(KIND_READ, ch, 8'($urandom), gates);
      else if (pick == 16)
        send_req(KIND_WRITE, ADDR_CTRL, ctrl_word(ch, ACC_LATCH, 3'($urandom), 1'($urandom)),
                 gates);
      else if (pick == 17) send_req(KIND_WRITE, ch, 8'($urandom_range(0, 9)), gates);
      else if (pick == 18) send_req(KIND_READ, 2'($urandom), 8'($urandom), gates);
      else send_req(tct_kind_e'($urandom_range(0, 3)), 2'($urandom), 8'($urandom), gates);
    end
  endtask

  initial begin
    int target;
    req_valid = 1'b0;
    req_kind = KIND_TICK;
    req_addr = '0;
    req_data = '0;
    gate_zero = 1'b0;
    gate_one = 1'b0;
    gate_two = 1'b0;
    rsp_ready = 1'b0;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    directed_checks();
    drain_results();

    target = useful_sent + RANDOM_ITEMS;
    while (useful_sent < target) begin
      case ($urandom_range(0, 9))
        0: noise_burst();
        1: begin
          drain_results();
          run_sequence();
        end
        default: run_sequence();
      endcase
    end

    @(negedge clk);
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);

    $display("Sent %0d ticks, %0d writes, %0d reads and %0d idle requests in %0d sequences.",
             kind_count[0], kind_count[1], kind_count[2], kind_count[3], seq_count);
    $display("Compared %0d results, %0d mismatches.", checked, fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
